/* hdl/resp_rf_pkg.sv */
// Shared constants and types for the RESP reply framer.
package resp_rf_pkg;

	localparam int MAX_NEST_DEPTH_DEF = 8;
	localparam int NUMBER_WIDTH_DEF = 32;
	localparam int LEN_W = 32;

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

	typedef struct packed {
		logic full;
		logic top_done;
	} stk_stat_t;

endpackage

/* hdl/resp_rf_stack.sv */
// Stack of remaining element counts for nested array replies.
module resp_rf_stack import resp_rf_pkg::*; #(
	parameter int MAX_NEST_DEPTH = MAX_NEST_DEPTH_DEF,
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stk_cmd_t                cmd,
	input  logic [NUMBER_WIDTH-1:0] push_count,
	output stk_stat_t               stat
);

	localparam int LW = $clog2(MAX_NEST_DEPTH + 1);
	localparam int IDX_W = (MAX_NEST_DEPTH > 1) ? $clog2(MAX_NEST_DEPTH) : 1;

	logic [LW-1:0]           nest_q;
	logic [NUMBER_WIDTH-1:0] cnt_q [MAX_NEST_DEPTH];
	logic                    one_q [MAX_NEST_DEPTH];

	logic [IDX_W-1:0]        sel;
	logic                    found;
	logic [NUMBER_WIDTH-1:0] sel_cnt;
	logic [IDX_W-1:0]        push_idx;

	// The innermost level whose count does not run out absorbs the finished element.
	always_comb begin
		sel = '0;
		found = 1'b0;
		for (int i = 0; i < MAX_NEST_DEPTH; i++) begin
			if ((LW'(i) < nest_q) && !one_q[i]) begin
				sel = IDX_W'(i);
				found = 1'b1;
			end
		end
	end

	assign sel_cnt = cnt_q[sel];
	assign push_idx = nest_q[IDX_W-1:0];
	assign stat.full = (nest_q == LW'(MAX_NEST_DEPTH));
	assign stat.top_done = !found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nest_q <= '0;
		end else if (cmd.push) begin
			nest_q <= nest_q + LW'(1);
		end else if (cmd.pop) begin
			nest_q <= found ? (LW'(sel) + LW'(1)) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			cnt_q[push_idx] <= push_count;
			one_q[push_idx] <= (push_count == NUMBER_WIDTH'(1));
		end else if (cmd.pop && found) begin
			cnt_q[sel] <= sel_cnt - NUMBER_WIDTH'(1);
			one_q[sel] <= (sel_cnt == NUMBER_WIDTH'(2));
		end
	end

endmodule

/* hdl/resp_rf_parse.sv */
// Byte decoder and framing state for the RESP reply framer.
module resp_rf_parse import resp_rf_pkg::*; #(
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              data_byte,
	input  stk_stat_t               stk_stat,
	output stk_cmd_t                stk_cmd,
	output logic [NUMBER_WIDTH-1:0] push_count,
	output logic                    reply_end,
	output logic [LEN_W-1:0]        reply_length,
	output logic                    malformed
);

	localparam int NW = NUMBER_WIDTH;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LINE,
		PH_LINE_CR,
		PH_BULK_HDR,
		PH_BULK_LF,
		PH_ARR_HDR,
		PH_ARR_LF,
		PH_PAYLOAD
	} phase_t;

	phase_t          phase_q, phase_d;
	logic            neg_q, neg_d;
	logic            dig_q, dig_d;
	logic [NW-1:0]   num_q, num_d;
	logic [NW:0]     left_q, left_d;
	logic [LEN_W-1:0] count_q, count_inc;
	logic            err_q;

	logic            fail, elem_done, push, done;
	logic [3:0]      digit;
	logic [NW+3:0]   num_x10;
	logic [NW:0]     left_m1;

	assign digit = 4'(data_byte - CH_0);
	assign num_x10 = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1) + (NW+4)'(digit);
	assign left_m1 = (left_q != '0) ? (left_q - (NW+1)'(1)) : '0;

	always_comb begin
		phase_d = phase_q;
		neg_d = neg_q;
		dig_d = dig_q;
		num_d = num_q;
		left_d = left_q;
		fail = 1'b0;
		elem_done = 1'b0;
		push = 1'b0;
		count_inc = (count_q == '1) ? count_q : (count_q + LEN_W'(1));
		case (phase_q)
			PH_TYPE: begin
				if (data_byte inside {CH_PLUS, CH_MINUS, CH_COLON}) begin
					phase_d = PH_LINE;
				end else if (data_byte == CH_DOLLAR || data_byte == CH_STAR) begin
					phase_d = (data_byte == CH_DOLLAR) ? PH_BULK_HDR : PH_ARR_HDR;
					neg_d = 1'b0;
					dig_d = 1'b0;
					num_d = '0;
				end else begin
					fail = 1'b1;
				end
			end
			PH_LINE: begin
				if (data_byte == CH_CR) phase_d = PH_LINE_CR;
			end
			PH_LINE_CR: begin
				if (data_byte == CH_LF) begin
					elem_done = 1'b1;
				end else if (data_byte != CH_CR) begin
					phase_d = PH_LINE;
				end
			end
			PH_BULK_HDR, PH_ARR_HDR: begin
				if (data_byte == CH_MINUS && !neg_q && !dig_q) begin
					neg_d = 1'b1;
				end else if (data_byte inside {[CH_0:CH_9]}) begin
					if (|num_x10[NW+3:NW]) begin
						fail = 1'b1;
					end else begin
						num_d = num_x10[NW-1:0];
						dig_d = 1'b1;
					end
				end else if (data_byte == CH_CR && dig_q) begin
					phase_d = (phase_q == PH_BULK_HDR) ? PH_BULK_LF : PH_ARR_LF;
				end else begin
					fail = 1'b1;
				end
			end
			PH_BULK_LF: begin
				if (data_byte != CH_LF) begin
					fail = 1'b1;
				end else if (neg_q) begin
					elem_done = 1'b1;
				end else begin
					left_d = {1'b0, num_q} + (NW+1)'(2);
					phase_d = PH_PAYLOAD;
				end
			end
			PH_ARR_LF: begin
				if (data_byte != CH_LF) begin
					fail = 1'b1;
				end else if (neg_q || num_q == '0) begin
					elem_done = 1'b1;
				end else if (stk_stat.full) begin
					fail = 1'b1;
				end else begin
					push = 1'b1;
					phase_d = PH_TYPE;
				end
			end
			PH_PAYLOAD: begin
				left_d = left_m1;
				if (left_m1 == '0) elem_done = 1'b1;
			end
			default: begin
				fail = 1'b1;
			end
		endcase
		if (elem_done) phase_d = PH_TYPE;
	end

	assign done = elem_done && stk_stat.top_done;
	assign stk_cmd.push = step && !err_q && push;
	assign stk_cmd.pop = step && !err_q && elem_done;
	assign push_count = num_q;
	assign reply_end = !err_q && !fail && done;
	assign reply_length = reply_end ? count_inc : '0;
	assign malformed = err_q || fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			neg_q <= 1'b0;
			dig_q <= 1'b0;
			num_q <= '0;
			left_q <= '0;
			count_q <= '0;
			err_q <= 1'b0;
		end else if (step && !err_q) begin
			phase_q <= phase_d;
			neg_q <= neg_d;
			dig_q <= dig_d;
			num_q <= num_d;
			left_q <= left_d;
			count_q <= done ? '0 : count_inc;
			err_q <= fail;
		end
	end

endmodule

/* hdl/resp_reply_framer_unit.sv */
// Top level of the RESP reply framer: input register, decoder, count stack, result register.
// The framer takes one reply byte per cycle and gives one result beat per byte; each byte
// passes through the byte register and then the result register. It keeps that rate under
// any stall pattern while the result side keeps up. The cycle between the byte register and
// the result register holds the type decode, one decimal digit step of the header number and
// the search of the count stack for the innermost array that still has elements left, so a
// finished element closes all of its enclosing arrays in that single cycle. After a framing
// error every later beat reports malformed with no reply end until reset.
module resp_reply_framer_unit import resp_rf_pkg::*; #(
	parameter int MAX_NEST_DEPTH = MAX_NEST_DEPTH_DEF,
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_ready,
	input  logic [7:0]       data_byte,
	output logic             reply_valid,
	input  logic             reply_ready,
	output logic             reply_end,
	output logic [LEN_W-1:0] reply_length,
	output logic             malformed
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    valid_s2;
	logic                    end_s2;
	logic [LEN_W-1:0]        length_s2;
	logic                    malformed_s2;
	logic                    advance;
	stk_cmd_t                stk_cmd;
	stk_stat_t               stk_stat;
	logic [NUMBER_WIDTH-1:0] push_count;
	logic                    end_d;
	logic [LEN_W-1:0]        length_d;
	logic                    malformed_d;

	assign advance = valid_s1 && (!valid_s2 || reply_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (byte_ready) valid_s1 <= byte_valid;
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (reply_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) byte_s1 <= data_byte;
		if (advance) begin
			end_s2 <= end_d;
			length_s2 <= length_d;
			malformed_s2 <= malformed_d;
		end
	end

	resp_rf_parse #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.data_byte(byte_s1),
		.stk_stat(stk_stat),
		.stk_cmd(stk_cmd),
		.push_count(push_count),
		.reply_end(end_d),
		.reply_length(length_d),
		.malformed(malformed_d)
	);

	resp_rf_stack #(
		.MAX_NEST_DEPTH(MAX_NEST_DEPTH),
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_stack (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(stk_cmd),
		.push_count(push_count),
		.stat(stk_stat)
	);

	assign reply_valid = valid_s2;
	assign reply_end = end_s2;
	assign reply_length = length_s2;
	assign malformed = malformed_s2;

	a_stack_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({stk_cmd.push, stk_cmd.pop}))
		else $error("Count stack pushed and popped in the same cycle.");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cmd.push |-> !stk_stat.full)
		else $error("Count stack pushed while full.");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(reply_valid && reply_end) |-> (!malformed && reply_length != '0))
		else $error("Reply end beat carries an error or a zero length.");

	a_len_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(reply_valid && !reply_end) |-> (reply_length == '0))
		else $error("Nonzero length on a beat that ends no reply.");

endmodule
